@@ design/shared_rgb_led_key_matrix_scanner_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the RGB LED and key matrix scanner
// Shared shorthand for the concurrent checks in the design modules.
// ----------------------------------------------------------------------------
`ifndef SHARED_RGB_LED_KEY_MATRIX_SCANNER_MACROS_SVH
`define SHARED_RGB_LED_KEY_MATRIX_SCANNER_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside of reset.
`define SRLKS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scanner check failed: same-cycle implication");

// Next-cycle implication, checked on the rising clock edge outside of reset.
`define SRLKS_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scanner check failed: next-cycle implication");

`endif

@@ design/srlks_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanner package
// Field widths, request and result codes, payload structs and the status
// bundle shared between the scan logic and the top level.
// ----------------------------------------------------------------------------
package srlks_pkg;

	localparam int unsigned REQ_W   = 2;
	localparam int unsigned LED_W   = 7;
	localparam int unsigned CH_W    = 8;
	localparam int unsigned RGB_W   = 3 * CH_W;
	localparam int unsigned ROW_W   = 3;
	localparam int unsigned COL_W   = 4;
	localparam int unsigned BITS_W  = 16;
	localparam int unsigned LINE_W  = 5;
	localparam int unsigned PHASE_W = 2;
	localparam int unsigned KIND_W  = 2;

	// Both stores are indexed by a 7-bit number.
	localparam int unsigned STORE_DEPTH = 128;
	localparam int unsigned MAX_ROWS    = 8;
	localparam int unsigned PHASES_PER_ROW = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_SET_COLOR = 2'd0,
		REQ_TICK      = 2'd1,
		REQ_COLLECT   = 2'd2,
		REQ_MAP       = 2'd3
	} req_e;

	typedef enum logic [KIND_W-1:0] {
		KIND_DUTY      = 2'd0,
		KIND_ROW       = 2'd1,
		KIND_NOT_READY = 2'd2
	} kind_e;

	localparam logic [PHASE_W-1:0] PHASE_BLUE  = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_GREEN = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_RED   = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [LED_W-1:0]  led_num;
		logic [CH_W-1:0]   red;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   blue;
		logic [ROW_W-1:0]  map_row;
		logic [COL_W-1:0]  map_column;
		logic [BITS_W-1:0] key_bits;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]  out_kind;
		logic [COL_W-1:0]   out_column;
		logic [CH_W-1:0]    duty;
		logic [PHASE_W-1:0] color_channel;
		logic [LINE_W-1:0]  drive_line;
		logic               line_enable;
		logic [ROW_W-1:0]   scan_row;
		logic [BITS_W-1:0]  scan_bits;
		logic               changed;
		logic               last;
	} out_item_t;

	// Commands from the top level into the scan logic.
	typedef struct packed {
		logic              tick;
		logic              collect;
		logic [BITS_W-1:0] key_bits;
		logic [ROW_W-1:0]  rd_row;
	} scan_cmd_t;

	// Drive position and capture status from the scan logic.
	typedef struct packed {
		logic [LINE_W-1:0]  line;
		logic [PHASE_W-1:0] phase;
		logic [ROW_W-1:0]   row;
		logic               done;
		logic               changed;
		logic [BITS_W-1:0]  rd_bits;
	} scan_stat_t;

endpackage

@@ design/srlks_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module srlks_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ design/srlks_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan sequencer
// Drive line, color phase and key row counters, the capture lock handshake
// and the captured and delivered key row images.
// ----------------------------------------------------------------------------
`include "shared_rgb_led_key_matrix_scanner_macros.svh"

module srlks_scan
	import srlks_pkg::*;
#(
	parameter int unsigned KEY_ROWS = 8,
	parameter int unsigned KEY_COLS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  scan_cmd_t  cmd,
	output scan_stat_t stat
);

	localparam logic [ROW_W:0]    RowsW   = (ROW_W + 1)'(KEY_ROWS);
	localparam logic [LINE_W:0]   Lines   = (LINE_W + 1)'(KEY_ROWS * PHASES_PER_ROW);
	localparam logic [BITS_W-1:0] ColMask = BITS_W'((17'd1 << KEY_COLS) - 17'd1);

	logic [LINE_W-1:0]  line_q;
	logic [PHASE_W-1:0] phase_q;
	logic [ROW_W-1:0]   row_q;
	logic [ROW_W-1:0]   first_q;
	logic               locked_q;
	logic               done_q;
	logic               chg_q;
	logic [MAX_ROWS-1:0][BITS_W-1:0] captured_q;
	logic [MAX_ROWS-1:0][BITS_W-1:0] delivered_q;

	logic [LINE_W:0]    line_inc;
	logic [LINE_W-1:0]  line_nx;
	logic [PHASE_W-1:0] phase_nx;
	logic [ROW_W-1:0]   row_cur;
	logic [ROW_W:0]     row_inc;
	logic [ROW_W-1:0]   row_nx;
	logic               lock_nx;
	logic               done_nx;
	logic [ROW_W-1:0]   first_nx;
	logic               cap_en;

	// The phase counter tracks the drive line modulo three; the line count is a
	// multiple of three, so both wrap together.
	always_comb begin
		line_inc = {1'b0, line_q} + (LINE_W + 1)'(1);
		line_nx  = (line_inc >= Lines) ? '0 : line_inc[LINE_W-1:0];
		if (line_nx == '0) begin
			phase_nx = PHASE_BLUE;
		end else if (phase_q == PHASE_RED) begin
			phase_nx = PHASE_BLUE;
		end else begin
			phase_nx = phase_q + PHASE_W'(1);
		end
		row_cur = ({1'b0, row_q} >= RowsW) ? '0 : row_q;
		row_inc = {1'b0, row_cur} + ((phase_nx == PHASE_RED) ? (ROW_W + 1)'(1) : '0);
		row_nx  = (row_inc >= RowsW) ? '0 : row_inc[ROW_W-1:0];
	end

	// Lock handshake: lock on the first tick, release once the row counter
	// steps back onto the row where the lock started.
	always_comb begin
		lock_nx  = locked_q;
		done_nx  = done_q;
		first_nx = first_q;
		cap_en   = 1'b0;
		if (!done_q) begin
			if (!locked_q) begin
				lock_nx  = 1'b1;
				first_nx = row_nx;
			end else if (row_cur != row_nx && row_nx == first_q) begin
				lock_nx = 1'b0;
				done_nx = 1'b1;
			end
			cap_en = lock_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q      <= '0;
			phase_q     <= PHASE_BLUE;
			row_q       <= '0;
			first_q     <= '0;
			locked_q    <= 1'b0;
			done_q      <= 1'b0;
			chg_q       <= 1'b0;
			captured_q  <= '0;
			delivered_q <= '0;
		end else if (cmd.tick) begin
			line_q   <= line_nx;
			phase_q  <= phase_nx;
			row_q    <= row_nx;
			first_q  <= first_nx;
			locked_q <= lock_nx;
			done_q   <= done_nx;
			if (cap_en) begin
				captured_q[row_nx] <= cmd.key_bits & ColMask;
			end
		end else if (cmd.collect && done_q) begin
			chg_q       <= (captured_q != delivered_q);
			delivered_q <= captured_q;
			done_q      <= 1'b0;
		end
	end

	assign stat.line    = line_q;
	assign stat.phase   = phase_q;
	assign stat.row     = row_q;
	assign stat.done    = done_q;
	assign stat.changed = chg_q;
	assign stat.rd_bits = captured_q[cmd.rd_row];

	`SRLKS_ASSERT_IMP(a_lock_done_excl, done_q, !locked_q)
	`SRLKS_ASSERT_NXT(a_done_needs_tick, !done_q && !cmd.tick, !done_q)
	`SRLKS_ASSERT_NXT(a_collect_clears, cmd.collect && done_q, !done_q)

endmodule

@@ design/shared_rgb_led_key_matrix_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared RGB LED and key matrix scanner
// Column-to-row LED matrix with hardware PWM duties and a locked key scan.
// ----------------------------------------------------------------------------
//  Channel | Signals                        | Payload
//  --------+--------------------------------+----------------------------------
//  request | req_valid, req_ready, req_item | in_item_t: one request
//  result  | rsp_valid, rsp_ready, rsp_item | out_item_t: one duty or row result
//
//  Set-color and map writes give no result.
//  A tick walks the columns, one column per cycle while the result is not
//  stalled, through a map read and a color read into the result register.
//  A collect gives one row result per key row, or a single not-ready result.
//  Reset clears every store at once through per-entry valid bits, so there is
//  no clearing pass. A stalled result freezes the whole column pipeline.
// ----------------------------------------------------------------------------
`include "shared_rgb_led_key_matrix_scanner_macros.svh"

module shared_rgb_led_key_matrix_scanner
	import srlks_pkg::*;
#(
	parameter int unsigned KEY_ROWS  = 8,
	parameter int unsigned KEY_COLS  = 16,
	parameter int unsigned LED_COUNT = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_item_t  req_item,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_item_t rsp_item
);

	localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
	localparam logic [7:0]       ColsW    = 8'(KEY_COLS);
	localparam logic [ROW_W:0]   RowsW    = (ROW_W + 1)'(KEY_ROWS);
	localparam logic [COL_W:0]   ColsLim  = (COL_W + 1)'(KEY_COLS);
	localparam logic [LED_W:0]   LedLimit = (LED_W + 1)'(LED_COUNT);
	localparam logic [COL_W-1:0] LastCol  = COL_W'(KEY_COLS - 1);
	localparam logic [ROW_W-1:0] LastRow  = ROW_W'(KEY_ROWS - 1);

	// One-hot control states.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_TICK = 3'b010,
		ST_COLL = 3'b100
	} state_t;

	state_t state_q;

	// Issue side of the column walk.
	logic [COL_W-1:0] col_q;
	logic             iss_q;
	// Stage 1: map entry read in flight; stage 2: color read in flight.
	logic             v_s1;
	logic [COL_W-1:0] col_s1;
	logic             mvld_s1;
	logic             v_s2;
	logic [COL_W-1:0] col_s2;
	logic             cvld_s2;
	logic             en_q;
	// Collect walk.
	logic [ROW_W-1:0] r_q;
	logic             nrdy_q;
	// Result register.
	logic             rsp_valid_q;
	out_item_t        rsp_q;
	out_item_t        rsp_nx;

	// Valid bits stand in for the reset contents of both memories.
	logic [STORE_DEPTH-1:0] color_vld_q;
	logic [STORE_DEPTH-1:0] map_vld_q;

	logic              accept;
	logic              adv;
	logic              set_color_wr;
	logic              map_wr;
	logic [ADDR_W-1:0] map_wr_addr;
	logic [ADDR_W-1:0] map_rd_addr;
	logic [LED_W-1:0]  map_rd_data;
	logic [LED_W-1:0]  led_idx_s1;
	logic [RGB_W-1:0]  color_rd_data;
	logic [RGB_W-1:0]  rgb_s2;
	logic [CH_W-1:0]   duty_s2;
	logic              en_now;
	scan_cmd_t         scan_cmd;
	scan_stat_t        scan_stat;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	// The whole walk moves only when the result register is free or draining.
	assign adv       = !rsp_valid_q || rsp_ready;

	// Writes land in the transfer cycle, which comes only while idle, with no column walk in flight.
	assign set_color_wr = accept && (req_item.req_type == REQ_SET_COLOR) &&
		({1'b0, req_item.led_num} < LedLimit);
	assign map_wr = accept && (req_item.req_type == REQ_MAP) &&
		({1'b0, req_item.map_row} < RowsW) && ({1'b0, req_item.map_column} < ColsLim);
	assign map_wr_addr = ADDR_W'(({5'd0, req_item.map_row} * ColsW) +
		{4'd0, req_item.map_column});
	assign map_rd_addr = ADDR_W'(({5'd0, scan_stat.row} * ColsW) + {4'd0, col_q});

	srlks_ram #(
		.WIDTH (LED_W),
		.DEPTH (STORE_DEPTH)
	) u_map_ram (
		.clk     (clk),
		.wr_en   (map_wr),
		.wr_addr (map_wr_addr),
		.wr_data (req_item.led_num),
		.rd_en   (adv),
		.rd_addr (map_rd_addr),
		.rd_data (map_rd_data)
	);

	// A never-written map entry points at LED zero.
	assign led_idx_s1 = mvld_s1 ? map_rd_data : '0;

	srlks_ram #(
		.WIDTH (RGB_W),
		.DEPTH (STORE_DEPTH)
	) u_color_ram (
		.clk     (clk),
		.wr_en   (set_color_wr),
		.wr_addr (req_item.led_num),
		.wr_data ({req_item.red, req_item.green, req_item.blue}),
		.rd_en   (adv),
		.rd_addr (led_idx_s1),
		.rd_data (color_rd_data)
	);

	// Unwritten colors and LEDs beyond the fitted count read as dark.
	assign rgb_s2 = cvld_s2 ? color_rd_data : '0;
	assign en_now = en_q || (rgb_s2 != '0);

	always_comb begin
		case (scan_stat.phase)
			PHASE_BLUE:  duty_s2 = rgb_s2[CH_W-1:0];
			PHASE_GREEN: duty_s2 = rgb_s2[2*CH_W-1:CH_W];
			default:     duty_s2 = rgb_s2[3*CH_W-1:2*CH_W];
		endcase
	end

	assign scan_cmd.tick     = accept && (req_item.req_type == REQ_TICK);
	assign scan_cmd.collect  = accept && (req_item.req_type == REQ_COLLECT);
	assign scan_cmd.key_bits = req_item.key_bits;
	assign scan_cmd.rd_row   = r_q;

	srlks_scan #(
		.KEY_ROWS (KEY_ROWS),
		.KEY_COLS (KEY_COLS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (scan_cmd),
		.stat   (scan_stat)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			iss_q       <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			en_q        <= 1'b0;
			r_q         <= '0;
			nrdy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			color_vld_q <= '0;
			map_vld_q   <= '0;
		end else begin
			if (set_color_wr) begin
				color_vld_q[req_item.led_num] <= 1'b1;
			end
			if (map_wr) begin
				map_vld_q[map_wr_addr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (adv) begin
						rsp_valid_q <= 1'b0;
					end
					if (scan_cmd.tick) begin
						state_q <= ST_TICK;
						col_q   <= '0;
						iss_q   <= 1'b1;
						en_q    <= 1'b0;
					end else if (scan_cmd.collect) begin
						state_q <= ST_COLL;
						r_q     <= '0;
						nrdy_q  <= !scan_stat.done;
					end
				end
				ST_TICK: begin
					if (adv) begin
						if (iss_q) begin
							col_q <= col_q + COL_W'(1);
							if (col_q == LastCol) begin
								iss_q <= 1'b0;
							end
						end
						v_s1        <= iss_q;
						v_s2        <= v_s1;
						rsp_valid_q <= v_s2;
						if (v_s2) begin
							en_q <= en_now;
							if (col_s2 == LastCol) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_COLL: begin
					if (adv) begin
						rsp_valid_q <= 1'b1;
						r_q         <= r_q + ROW_W'(1);
						if (nrdy_q || r_q == LastRow) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Next result: a row or not-ready during a collect, a column duty otherwise.
	always_comb begin
		rsp_nx = '0;
		if (state_q == ST_COLL) begin
			if (nrdy_q) begin
				rsp_nx.out_kind = KIND_NOT_READY;
				rsp_nx.last     = 1'b1;
			end else begin
				rsp_nx.out_kind  = KIND_ROW;
				rsp_nx.scan_row  = r_q;
				rsp_nx.scan_bits = scan_stat.rd_bits;
				rsp_nx.changed   = scan_stat.changed;
				rsp_nx.last      = (r_q == LastRow);
			end
		end else begin
			rsp_nx.out_kind      = KIND_DUTY;
			rsp_nx.out_column    = col_s2;
			rsp_nx.duty          = duty_s2;
			rsp_nx.color_channel = scan_stat.phase;
			rsp_nx.drive_line    = scan_stat.line;
			rsp_nx.line_enable   = (col_s2 == LastCol) && en_now;
			rsp_nx.last          = (col_s2 == LastCol);
		end
	end

	// Pipeline payload and the result register.
	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1  <= col_q;
			mvld_s1 <= map_vld_q[map_rd_addr];
			col_s2  <= col_s1;
			cvld_s2 <= color_vld_q[led_idx_s1] && ({1'b0, led_idx_s1} < LedLimit);
			if ((state_q == ST_TICK && v_s2) || state_q == ST_COLL) begin
				rsp_q <= rsp_nx;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	`SRLKS_ASSERT_IMP(a_idle_drained, state_q == ST_IDLE, !iss_q && !v_s1 && !v_s2)
	`SRLKS_ASSERT_IMP(a_last_duty_col,
		rsp_valid_q && rsp_q.last && rsp_q.out_kind == KIND_DUTY, rsp_q.out_column == LastCol)
	`SRLKS_ASSERT_NXT(a_rsp_held, rsp_valid_q && !rsp_ready, rsp_valid_q && $stable(rsp_q))

endmodule
